// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [CHAR_WIDTH-1:0]  DIGIT_BIAS  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0]  LETTER_BIAS = 8'd55;
   localparam logic [CHAR_WIDTH-1:0]  MINUS_CHAR  = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0]  ZERO_CHAR   = 8'h30;
   localparam logic [DIGIT_WIDTH-1:0] LAST_DECIMAL = 6'd9;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic read;
      logic emit_sign;
      logic emit_zero;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic mag_zero;
      logic count_zero;
      logic negative;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/int_to_ascii_radix_unit.sv =====
// ----------------------------------------------------------------------------
// int_to_ascii_radix_unit
// Converts a signed integer to ASCII text in radix 2 to 36, one character
// per response, most significant character first.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each digit comes
// from a bit-serial restoring divider whose remainder goes into a digit
// store. When the magnitude reaches zero, a '-' is sent for a negative
// value, then each digit is read back from the store and output (store
// read, then output), the last digit stored going out first.
// Characters appear on rsp_character with rsp_valid high for one cycle
// each and rsp_last on the final one; the receiver cannot stall, so every
// strobe must be captured. Radix values below 2 act as 2, above 36 as 36.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_ascii_radix_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic signed [VALUE_WIDTH-1:0]       req_value,
   input  wire logic [itoa_pkg::RADIX_WIDTH-1:0]    req_radix,
   output      logic                                rsp_valid,
   output      logic [itoa_pkg::CHAR_WIDTH-1:0]     rsp_character,
   output      logic                                rsp_last
);

   itoa_pkg::cmd_type    cmd;
   itoa_pkg::status_type status;

   itoa_ctrl #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   itoa_dp #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .req_radix    (req_radix),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/itoa_dp.sv =====
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude register, bit-serial restoring divider, digit store
// and registered character output.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dp #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic signed [VALUE_WIDTH-1:0]           req_value,
   input  wire logic [itoa_pkg::RADIX_WIDTH-1:0]        req_radix,
   input  wire itoa_pkg::cmd_type                       cmd,
   output      itoa_pkg::status_type                    status,
   output      logic                                    rsp_valid,
   output      logic [itoa_pkg::CHAR_WIDTH-1:0]         rsp_character,
   output      logic                                    rsp_last
);

   localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0]               mag_ff, mag_in;
   logic [itoa_pkg::RADIX_WIDTH-1:0]     radix_ff, radix_in;
   logic [itoa_pkg::DIGIT_WIDTH-1:0]     rem_ff, rem_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic                                 neg_ff, neg_in;
   logic [itoa_pkg::DIGIT_WIDTH-1:0]     store_mem [VALUE_WIDTH];
   logic [itoa_pkg::DIGIT_WIDTH-1:0]     rd_data_ff;
   logic [AW-1:0]                        rd_addr;
   logic [CW-1:0]                        count_dec;
   logic [itoa_pkg::DIGIT_WIDTH:0]       trial;
   logic                                 q_bit;
   logic [itoa_pkg::CHAR_WIDTH-1:0]      digit_char;
   logic                                 valid_ff, valid_in;
   logic [itoa_pkg::CHAR_WIDTH-1:0]      char_ff, char_in;
   logic                                 last_ff, last_in;

   assign count_dec = count_ff - CW'(1);
   assign rd_addr   = count_dec[AW-1:0];
   assign trial     = {rem_ff, mag_ff[VALUE_WIDTH-1]};
   assign q_bit     = (trial >= {1'b0, radix_ff});
   assign digit_char = (rd_data_ff > itoa_pkg::LAST_DECIMAL)
                     ? ({2'b00, rd_data_ff} + itoa_pkg::LETTER_BIAS)
                     : ({2'b00, rd_data_ff} + itoa_pkg::DIGIT_BIAS);

   always_comb begin
      mag_in   = mag_ff;
      radix_in = radix_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      priority if (cmd.load) begin
         neg_in   = req_value[VALUE_WIDTH-1];
         mag_in   = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;
         if (req_radix < itoa_pkg::RADIX_MIN) begin
            radix_in = itoa_pkg::RADIX_MIN;
         end else if (req_radix > itoa_pkg::RADIX_MAX) begin
            radix_in = itoa_pkg::RADIX_MAX;
         end else begin
            radix_in = req_radix;
         end
         rem_in   = '0;
         count_in = '0;
      end else if (cmd.div_step) begin
         mag_in = {mag_ff[VALUE_WIDTH-2:0], q_bit};
         rem_in = q_bit ? trial[itoa_pkg::DIGIT_WIDTH-1:0] - radix_ff
                        : trial[itoa_pkg::DIGIT_WIDTH-1:0];
      end else if (cmd.store) begin
         rem_in   = '0;
         count_in = count_ff + CW'(1);
      end else if (cmd.read) begin
         count_in = count_dec;
      end
   end

   always_comb begin
      valid_in = cmd.emit_sign | cmd.emit_zero | cmd.emit_digit;
      char_in  = char_ff;
      last_in  = last_ff;
      unique case (1'b1)
         cmd.emit_sign: begin
            char_in = itoa_pkg::MINUS_CHAR;
            last_in = 1'b0;
         end
         cmd.emit_zero: begin
            char_in = itoa_pkg::ZERO_CHAR;
            last_in = 1'b1;
         end
         cmd.emit_digit: begin
            char_in = digit_char;
            last_in = (count_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff   <= '0;
         rem_ff   <= '0;
         count_ff <= '0;
         neg_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         mag_ff   <= mag_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
         neg_ff   <= neg_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[count_ff[AW-1:0]] <= rem_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign status.mag_zero   = (mag_ff == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.negative   = neg_ff;

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== rtl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences load, digit division, sign, a lone zero, and reverse digit output.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_ctrl #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire itoa_pkg::status_type status,
   output      itoa_pkg::cmd_type    cmd
);

   localparam int SW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_DIVIDE = 8'b0000_0100,
      ST_STORE  = 8'b0000_1000,
      ST_SIGN   = 8'b0001_0000,
      ST_ZERO   = 8'b0010_0000,
      ST_READ   = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic          step_last;

   assign step_last = (step_ff == SW'(VALUE_WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            priority if (!status.mag_zero) begin
               state_in = ST_DIVIDE;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else if (status.count_zero) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + SW'(1);
            if (step_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = status.count_zero ? ST_ZERO : ST_READ;
         end
         ST_ZERO: begin
            cmd.emit_zero = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            state_in       = status.count_zero ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== tb/int_to_ascii_radix_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_ascii_radix_unit_test
// Drives signed integers and radix values into the converter and checks each
// character strobe against a model of the text the number should produce:
// extremes of the value range, clamped radix values, back-to-back and gapped
// requests, a pause until the response stream drains, and a random mix.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_unit_test;

   localparam int VALUE_WIDTH = 32;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 80;
   localparam int RANDOM_REQUESTS = 95;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [itoa_pkg::CHAR_WIDTH-1:0] character;
      logic                            last;
   } text_char_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic signed [VALUE_WIDTH-1:0]        req_value = '0;
   logic [itoa_pkg::RADIX_WIDTH-1:0]     req_radix = '0;
   logic                                 rsp_valid;
   logic [itoa_pkg::CHAR_WIDTH-1:0]      rsp_character;
   logic                                 rsp_last;

   text_char_type pending_chars[$];
   text_char_type expected_char;
   int            mismatch_count = 0;
   int            cycle_count = 0;

   int_to_ascii_radix_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_radix(req_radix),
      .rsp_valid(rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input text_char_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                  $realtime, what, want.character, want.last, rsp_character, rsp_last);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_chars.size() == 0) begin
            note_mismatch("unexpected character", '0);
         end else begin
            expected_char = pending_chars.pop_front();
            if (rsp_character !== expected_char.character || rsp_last !== expected_char.last)
               note_mismatch("character mismatch", expected_char);
         end
      end
   end

   // Spell the number most significant character first.
   task automatic spell_number(input logic [VALUE_WIDTH-1:0] value,
                               input logic [itoa_pkg::RADIX_WIDTH-1:0] radix);
      logic [itoa_pkg::RADIX_WIDTH-1:0] base;
      logic [VALUE_WIDTH-1:0]           magnitude;
      logic [VALUE_WIDTH-1:0]           remainder;
      logic [itoa_pkg::DIGIT_WIDTH-1:0] digits[$];
      logic [itoa_pkg::DIGIT_WIDTH-1:0] digit;
      text_char_type                    text_char;
      base = radix;
      if (base < itoa_pkg::RADIX_MIN)
         base = itoa_pkg::RADIX_MIN;
      if (base > itoa_pkg::RADIX_MAX)
         base = itoa_pkg::RADIX_MAX;
      magnitude = value[VALUE_WIDTH-1] ? -value : value;
      while (magnitude != 0) begin
         remainder = magnitude % base;
         digits.push_back(remainder[itoa_pkg::DIGIT_WIDTH-1:0]);
         magnitude = magnitude / base;
      end
      if (value[VALUE_WIDTH-1]) begin
         text_char.character = itoa_pkg::MINUS_CHAR;
         text_char.last = 1'b0;
         pending_chars.push_back(text_char);
      end
      if (digits.size() == 0) begin
         text_char.character = itoa_pkg::ZERO_CHAR;
         text_char.last = 1'b1;
         pending_chars.push_back(text_char);
      end else begin
         for (int i = digits.size() - 1; i >= 0; i--) begin
            digit = digits[i];
            text_char.character = (digit > itoa_pkg::LAST_DECIMAL)
                                ? itoa_pkg::LETTER_BIAS + digit
                                : itoa_pkg::DIGIT_BIAS + digit;
            text_char.last = (i == 0);
            pending_chars.push_back(text_char);
         end
      end
   endtask

   task automatic send_request(input logic [VALUE_WIDTH-1:0] value,
                               input logic [itoa_pkg::RADIX_WIDTH-1:0] radix);
      int gap;
      gap = $urandom_range(0, 11);
      repeat (gap) @(negedge clock);
      req_value = value;
      req_radix = radix;
      start = 1'b1;
      do
         @(posedge clock);
      while (busy);
      spell_number(value, radix);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_chars.size() != 0)
         @(negedge clock);
   endtask

   task automatic test_extremes();
      send_request(32'd0, 6'd10);
      send_request(32'd0, 6'd2);
      send_request(32'd1, 6'd36);
      send_request(-32'sd1, 6'd10);
      send_request(32'h7FFF_FFFF, 6'd2);
      send_request(32'h7FFF_FFFF, 6'd10);
      send_request(32'h7FFF_FFFF, 6'd36);
      send_request(32'h8000_0000, 6'd2);
      send_request(32'h8000_0000, 6'd10);
      send_request(32'h8000_0000, 6'd16);
      send_request(32'h8000_0000, 6'd36);
      send_request(32'd35, 6'd36);
      send_request(32'd10, 6'd11);
      send_request(32'd9, 6'd10);
      send_request(32'hDEAD_BEEF, 6'd16);
      send_request(-32'sd1295, 6'd36);
   endtask

   task automatic test_radix_clamp();
      send_request(32'd255, 6'd0);
      send_request(-32'sd100, 6'd1);
      send_request(32'h8000_0000, 6'd0);
      send_request(32'd1295, 6'd37);
      send_request(-32'sd1, 6'd63);
      send_request(32'h7FFF_FFFF, 6'd63);
   endtask

   task automatic test_drain_pause();
      send_request(-32'sd12345, 6'd7);
      wait_drained();
      send_request(32'd123456789, 6'd3);
      wait_drained();
      send_request(32'h5555_5555, 6'd2);
   endtask

   task automatic test_random();
      logic [VALUE_WIDTH-1:0]           value;
      logic [itoa_pkg::RADIX_WIDTH-1:0] radix;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom_range(0, 100);
            2: value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                            : 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: value = $urandom >> $urandom_range(0, 31);
         endcase
         if ($urandom_range(0, 1))
            value = -value;
         if ($urandom_range(0, 9) == 0)
            radix = $urandom_range(0, 63);
         else
            radix = $urandom_range(2, 36);
         // hold off now and then until every character is out
         if (n % 30 == 29)
            wait_drained();
         send_request(value, radix);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_radix_clamp();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_chars.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
